// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon zone test.
package pip_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_SET_BOX    = 2'd0,
    OP_ADD_VERTEX = 2'd1,
    OP_WIDEN_Z    = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  localparam int OP_BITS     = 2;
  localparam int OUT_TDATA_W = 8;

  // Controller to datapath commands
  typedef struct packed {
    logic take;        // input transfer this cycle
    op_t  op;          // kind of the transferred item
    logic walk_start;  // query enters the edge walk
    logic walk_issue;  // issue one vertex read
  } pip_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic poly_mode;   // zone is a polygon
    logic in_box;      // incoming point lies in the bounding box
    logic store_full;  // vertex store holds its maximum
    logic walk_last;   // current read closes the ring
    logic pipe_busy;   // edge pipeline still holds work
    logic parity;      // crossing count, low bit
  } pip_sts_t;

endpackage

// ----- rtl/pip_ctrl.sv -----
// Controller: handshakes, walk sequencing and the output register.
module pip_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_valid,
  output logic                            s_ready,
  input  pip_pkg::op_t                    op,
  input  logic                            m_ready,
  output logic                            m_valid,
  output logic [pip_pkg::OUT_TDATA_W-1:0] m_data,
  input  pip_pkg::pip_sts_t               sts,
  output pip_pkg::pip_cmd_t               cmd
);
  import pip_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t state;
  logic   out_free;
  logic   out_load;
  logic   take;
  logic   to_walk;
  logic   imm_inside;
  logic   imm_dropped;

  // Handshake and command decode
  assign out_free    = !m_valid || m_ready;
  assign s_ready     = (state == ST_IDLE) && out_free;
  assign take        = s_valid && s_ready;
  assign to_walk     = take && (op == OP_QUERY) && sts.poly_mode && sts.in_box;
  assign imm_inside  = (op == OP_QUERY) && !sts.poly_mode && sts.in_box;
  assign imm_dropped = (op == OP_ADD_VERTEX) && sts.store_full;

  // A result enters the output register: immediate answer or end of the walk
  assign out_load = (take && !to_walk) ||
                    ((state == ST_DRAIN) && !sts.pipe_busy && out_free);

  assign cmd.take       = take;
  assign cmd.op         = op;
  assign cmd.walk_start = to_walk;
  assign cmd.walk_issue = (state == ST_WALK);

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
      m_data  <= '0;
    end else begin
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (to_walk) begin
              state <= ST_WALK;
            end else begin
              m_data <= {6'b0, imm_dropped, imm_inside};
            end
          end
        end
        ST_WALK: begin
          if (sts.walk_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            m_data <= {6'b0, 1'b0, sts.parity};
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/pip_dp.sv -----
// Datapath: zone state, vertex memory and the pipelined edge crossing test.
module pip_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_pkg::pip_cmd_t            cmd,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  input  logic signed [COORD_BITS-1:0] qz,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  output pip_pkg::pip_sts_t            sts
);
  import pip_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam logic signed [W-1:0] C_TOP = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] C_BOT = {1'b1, {(W-1){1'b0}}};

  // Zone state
  logic signed [W-1:0] cmin [3];
  logic signed [W-1:0] cmax [3];
  logic signed [W-1:0] pt   [3];
  logic signed [W-1:0] hi_q [3];
  logic [CW-1:0]       count;
  logic                poly_mode;
  logic                full;
  logic                in_box;
  logic                add_ok;

  // Vertex memory, y in the upper half
  logic [2*W-1:0] mem [MAX_VERTICES];
  logic [2*W-1:0] rd_data;
  logic           rd_vld;
  logic           rd_first;
  logic [CW-1:0]  k;
  logic           walk_last;
  logic [AW-1:0]  rd_addr;

  // Query point held for the walk
  logic signed [W-1:0] xq;
  logic signed [W-1:0] yq;

  // Edge stage signals
  logic [2*W-1:0]       prev;
  logic signed [W-1:0]  ax, ay, bx, by, hx, hy, lx, ly;
  logic                 flat, off_y, left_side, right_side;
  logic                 e1_vld, e1_yes, e1_chk;
  logic signed [DW-1:0] e1_da, e1_db, e1_dc, e1_dd;
  logic                 e2_vld, e2_yes, e2_chk;
  logic signed [PW-1:0] e2_p1, e2_p2;
  logic                 parity;

  assign pt[0]   = px;
  assign pt[1]   = py;
  assign pt[2]   = pz;
  assign hi_q[0] = qx;
  assign hi_q[1] = qy;
  assign hi_q[2] = qz;

  assign full   = (count == CW'(MAX_VERTICES));
  assign add_ok = cmd.take && (cmd.op == OP_ADD_VERTEX) && !full;

  // Bounding box test on the incoming point
  always_comb begin
    in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (pt[i] < cmin[i] || pt[i] > cmax[i]) begin
        in_box = 1'b0;
      end
    end
  end

  // Zone state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      poly_mode <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cmin[i] <= C_TOP;
        cmax[i] <= C_BOT;
      end
    end else if (cmd.take) begin
      case (cmd.op)
        OP_SET_BOX: begin
          poly_mode <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            cmin[i] <= pt[i];
            cmax[i] <= hi_q[i];
          end
        end
        OP_ADD_VERTEX: begin
          if (!full) begin
            poly_mode <= 1'b1;
            count     <= count + 1'b1;
            for (int i = 0; i < 3; i++) begin
              if (cmax[i] < pt[i]) cmax[i] <= pt[i];
              if (cmin[i] > pt[i]) cmin[i] <= pt[i];
            end
          end
        end
        OP_WIDEN_Z: begin
          if (cmax[2] < pz || cmax[2] < qz) begin
            cmax[2] <= (pz > qz) ? pz : qz;
          end
          if (cmin[2] > pz || cmin[2] > qz) begin
            cmin[2] <= (pz < qz) ? pz : qz;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk index: reads 0..count-1, then vertex 0 again to close the ring
  assign walk_last = (k == count);
  assign rd_addr   = walk_last ? '0 : k[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.walk_start) begin
      k <= '0;
    end else if (cmd.walk_issue) begin
      k <= k + 1'b1;
    end
  end

  // Memory write on add, registered read during the walk
  always_ff @(posedge clk) begin
    if (add_ok) begin
      mem[count[AW-1:0]] <= {py, px};
    end
    if (cmd.walk_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cmd.op == OP_QUERY) begin
      xq <= px;
      yq <= py;
    end
  end

  // Edge test, first stage: order the ends and classify
  assign ax = prev[W-1:0];
  assign ay = prev[2*W-1:W];
  assign bx = rd_data[W-1:0];
  assign by = rd_data[2*W-1:W];

  always_comb begin
    flat = (ay == by);
    if (ay > by) begin
      hx = ax; hy = ay; lx = bx; ly = by;
    end else begin
      hx = bx; hy = by; lx = ax; ly = ay;
    end
    off_y      = (hy > yq && ly > yq) || (hy < yq && ly < yq);
    left_side  = (hx < xq) && (lx < xq);
    right_side = (hx >= xq) && (lx >= xq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
      e1_vld   <= 1'b0;
      e2_vld   <= 1'b0;
      parity   <= 1'b0;
    end else begin
      rd_vld   <= cmd.walk_issue;
      rd_first <= (k == '0);
      e1_vld   <= rd_vld && !rd_first;
      e2_vld   <= e1_vld;
      // Last stage: compare products and count the crossing
      if (cmd.walk_start) begin
        parity <= 1'b0;
      end else if (e2_vld && (e2_yes || (e2_chk && e2_p1 <= e2_p2))) begin
        parity <= ~parity;
      end
    end
  end

  // Edge pipeline payload
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev <= rd_data;
    end
    e1_yes <= !flat && !off_y && !left_side && right_side;
    e1_chk <= !flat && !off_y && !left_side && !right_side;
    e1_da  <= DW'(yq) - DW'(hy);
    e1_db  <= DW'(lx) - DW'(hx);
    e1_dc  <= DW'(xq) - DW'(hx);
    e1_dd  <= DW'(ly) - DW'(hy);
    // Second stage: the two cross products
    e2_yes <= e1_yes;
    e2_chk <= e1_chk;
    e2_p1  <= e1_da * e1_db;
    e2_p2  <= e1_dc * e1_dd;
  end

  assign sts.poly_mode  = poly_mode;
  assign sts.in_box     = in_box;
  assign sts.store_full = full;
  assign sts.walk_last  = walk_last;
  assign sts.pipe_busy  = rd_vld || e1_vld || e2_vld;
  assign sts.parity     = parity;

endmodule

// ----- rtl/point_in_polygon_zone_test_unit.sv -----
// Top level of the point-in-polygon zone test unit.
// Set box, add vertex, widen z, and any query answered by the bounding box alone
// (box mode, or a point outside the box) take one transfer each, with no walk.
// A polygon query inside the box walks the vertex ring through the single read
// port of the vertex memory, one vertex a cycle (vertex_count + 1 reads, the
// first vertex read again to close the ring), then drains the edge pipeline
// (read register, order and classify, cross products, compare and count), and
// its result is loaded once that pipeline is empty and the output register is
// free or being read. A new item is taken once the result of the previous one
// is in the output register and that register is free or being read, so a
// stalled result stalls the input. The vertex memory needs no clearing pass.
`include "assert_macros.svh"

module point_in_polygon_zone_test_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // px, py, pz, qx, qy, qz, COORD_BITS each, zero padded to whole bytes
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // op
  input  logic [pip_pkg::OP_BITS-1:0]           s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // inside_res, vertex_dropped, zero padded
  output logic [pip_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import pip_pkg::*;

  localparam int W = COORD_BITS;

  pip_cmd_t        cmd;
  pip_sts_t        sts;
  logic signed [W-1:0] px, py, pz, qx, qy, qz;

  // Unpack the input transfer
  assign px = s_axis_tdata[0*W +: W];
  assign py = s_axis_tdata[1*W +: W];
  assign pz = s_axis_tdata[2*W +: W];
  assign qx = s_axis_tdata[3*W +: W];
  assign qy = s_axis_tdata[4*W +: W];
  assign qz = s_axis_tdata[5*W +: W];

  pip_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .op      (op_t'(s_axis_tuser)),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_data  (m_axis_tdata),
    .sts     (sts),
    .cmd     (cmd)
  );

  pip_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .px  (px),
    .py  (py),
    .pz  (pz),
    .qz  (qz),
    .qx  (qx),
    .qy  (qy),
    .sts (sts)
  );

  // Checks
  `ASSERT_SAME(a_no_take_in_walk, cmd.walk_issue || sts.pipe_busy, !s_axis_tready, "take in walk")
  `ASSERT_NEXT(a_issue_fills_pipe, cmd.walk_issue, sts.pipe_busy, "vertex read lost")
  `ASSERT_SAME(a_flags_exclusive, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "both flags")

endmodule

// ----- test/point_in_polygon_zone_test_unit_test.sv -----
// Testbench for the point-in-polygon zone test unit: directed and random items, self-checking.
module point_in_polygon_zone_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int MAX_VERTS = 64;
  localparam int COORD_W = 24;
  localparam longint COORD_TOP = 64'sd8388607;
  localparam longint COORD_BOT = -64'sd8388608;
  localparam int DRAIN_CYCLES = MAX_VERTS + 16;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    op_t    op;
    coord_t px, py, pz, qx, qy, qz;
  } zone_item_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // px, py, pz, qx, qy, qz from the lowest bit up, 24 bits each
  logic [6*COORD_W-1:0] s_axis_tdata;
  // op
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // inside_res, vertex_dropped from the lowest bit up, zero padded
  logic [7:0] m_axis_tdata;

  // Zone state as the block should hold it
  coord_t vx_mem[MAX_VERTS];
  coord_t vy_mem[MAX_VERTS];
  int unsigned n_vertices;
  bit poly_zone;
  coord_t lo_c[3];
  coord_t hi_c[3];

  // Expected {vertex_dropped, inside_res} per accepted item, oldest first
  logic [1:0] pending_flags_q[$];

  bit no_gaps;
  int error_count;
  int item_count;
  int query_count;
  int inside_count;
  int drop_count;

  point_in_polygon_zone_test_unit #(
    .MAX_VERTICES(MAX_VERTS),
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Zone predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_zone();
    n_vertices = 0;
    poly_zone = 1'b0;
    for (int i = 0; i < MAX_VERTS; i++) begin
      vx_mem[i] = '0;
      vy_mem[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      lo_c[i] = coord_t'(COORD_TOP);
      hi_c[i] = coord_t'(COORD_BOT);
    end
  endfunction

  function automatic void stretch_axis(int axis, coord_t v);
    if (hi_c[axis] < v) hi_c[axis] = v;
    if (lo_c[axis] > v) lo_c[axis] = v;
  endfunction

  // Does the half-line from (x,y) towards +x cut edge a-b?
  function automatic bit edge_cut(longint x, longint y, longint ax, longint ay,
                                  longint bx, longint by);
    longint hx, hy, lx, ly;
    if (ay == by) return 1'b0;
    if (ay > by) begin
      hx = ax; hy = ay; lx = bx; ly = by;
    end else begin
      hx = bx; hy = by; lx = ax; ly = ay;
    end
    if ((hy > y && ly > y) || (hy < y && ly < y)) return 1'b0;
    if (hx < x && lx < x) return 1'b0;
    if (hx >= x && lx >= x) return 1'b1;
    // crossing at or right of x, cross-multiplied (ly - hy is negative)
    return (y - hy) * (lx - hx) <= (x - hx) * (ly - hy);
  endfunction

  // Apply one item to the zone state; returns {vertex_dropped, inside_res}
  function automatic logic [1:0] predict_zone(zone_item_t it);
    coord_t p[3];
    coord_t q[3];
    logic hit, dropped, in_box;
    int cuts, nxt;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    q[0] = it.qx; q[1] = it.qy; q[2] = it.qz;
    hit = 1'b0;
    dropped = 1'b0;
    case (it.op)
      OP_SET_BOX: begin
        poly_zone = 1'b0;
        for (int i = 0; i < 3; i++) begin
          lo_c[i] = p[i];
          hi_c[i] = q[i];
        end
      end
      OP_ADD_VERTEX: begin
        if (n_vertices >= MAX_VERTS) begin
          dropped = 1'b1;
        end else begin
          poly_zone = 1'b1;
          vx_mem[n_vertices] = p[0];
          vy_mem[n_vertices] = p[1];
          n_vertices++;
          for (int i = 0; i < 3; i++) stretch_axis(i, p[i]);
        end
      end
      OP_WIDEN_Z: begin
        stretch_axis(2, p[2]);
        stretch_axis(2, q[2]);
      end
      default: begin
        in_box = 1'b1;
        for (int i = 0; i < 3; i++)
          if (p[i] < lo_c[i] || p[i] > hi_c[i]) in_box = 1'b0;
        if (!poly_zone) begin
          hit = in_box;
        end else if (in_box) begin
          cuts = 0;
          for (int n = 0; n < n_vertices; n++) begin
            nxt = (n + 1 >= n_vertices) ? 0 : n + 1;
            if (edge_cut(p[0], p[1], vx_mem[n], vy_mem[n], vx_mem[nxt], vy_mem[nxt]))
              cuts++;
          end
          hit = cuts[0];
        end
      end
    endcase
    return {dropped, hit};
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_TOP) return coord_t'(COORD_TOP);
    if (v < COORD_BOT) return coord_t'(COORD_BOT);
    return coord_t'(v);
  endfunction

  function automatic coord_t near(longint c, int unsigned spread);
    return clamp_coord(c + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
  endfunction

  function automatic zone_item_t make_item(op_t op, longint px, longint py, longint pz,
                                           longint qx, longint qy, longint qz);
    zone_item_t it;
    it.op = op;
    it.px = coord_t'(px); it.py = coord_t'(py); it.pz = coord_t'(pz);
    it.qx = coord_t'(qx); it.qy = coord_t'(qy); it.qz = coord_t'(qz);
    return it;
  endfunction

  // All fields random, unused ones included
  function automatic zone_item_t random_item(op_t op);
    zone_item_t it;
    it.op = op;
    it.px = any_coord(); it.py = any_coord(); it.pz = any_coord();
    it.qx = any_coord(); it.qy = any_coord(); it.qz = any_coord();
    return it;
  endfunction

  // Point somewhere between two bounds, or anywhere if they are inverted
  function automatic coord_t between(coord_t lo, coord_t hi);
    if (lo > hi) return any_coord();
    return coord_t'(longint'(lo) + longint'($urandom) % (longint'(hi) - lo + 1));
  endfunction

  // Vertex: mostly in a small cluster so queries land near edges
  function automatic zone_item_t pick_vertex();
    zone_item_t it;
    int r;
    it = random_item(OP_ADD_VERTEX);
    r = $urandom_range(0, 99);
    if (r < 85) begin
      it.px = near(0, 300); it.py = near(0, 300); it.pz = near(0, 50);
    end else if (r < 95) begin
      it.px = near(0, 1 << 20); it.py = near(0, 1 << 20); it.pz = near(0, 1 << 20);
    end
    return it;
  endfunction

  // Polygon query: vertices, vertex heights, edge midpoints, cluster, anywhere
  function automatic zone_item_t pick_query();
    zone_item_t it;
    int r, a, b;
    it = random_item(OP_QUERY);
    r = $urandom_range(0, 99);
    a = (n_vertices == 0) ? 0 : $urandom_range(0, n_vertices - 1);
    b = (a + 1 >= n_vertices) ? 0 : a + 1;
    if (n_vertices == 0 || r < 15) begin
      it.px = near(0, 350); it.py = near(0, 350);
    end else if (r < 40) begin
      it.px = near(vx_mem[a], 40); it.py = vy_mem[a];
    end else if (r < 55) begin
      it.px = vx_mem[a]; it.py = vy_mem[a];
    end else if (r < 75) begin
      it.px = coord_t'((longint'(vx_mem[a]) + vx_mem[b]) >>> 1);
      it.py = coord_t'((longint'(vy_mem[a]) + vy_mem[b]) >>> 1);
    end else if (r < 92) begin
      it.px = near(vx_mem[a], 200); it.py = near(vy_mem[b], 200);
    end
    if ($urandom_range(0, 9) != 0) it.pz = between(lo_c[2], hi_c[2]);
    return it;
  endfunction

  // Box query coordinate: on, just past, or between the bounds, or anywhere
  function automatic coord_t box_axis(coord_t lo, coord_t hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return clamp_coord(longint'(lo) - 1);
      3: return clamp_coord(longint'(hi) + 1);
      4: return between(lo, hi);
      default: return any_coord();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and result handling
  // ---------------------------------------------------------------------------

  task automatic send_item(zone_item_t it);
    int gap;
    logic [1:0] flags;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {it.qz, it.qy, it.qx, it.pz, it.py, it.px};
    do @(posedge clk); while (!s_axis_tready);
    flags = predict_zone(it);
    pending_flags_q = {pending_flags_q, flags};
    item_count++;
    if (it.op == OP_QUERY) query_count++;
    if (flags[0]) inside_count++;
    if (flags[1]) drop_count++;
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_flags_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // Result side back-pressure
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_flags_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata %h", m_axis_tdata));
      end else begin
        want = pending_flags_q.pop_front();
        if (m_axis_tdata[0] !== want[0])
          report_mismatch($sformatf("inside_res expected %0b got %0b",
                                    want[0], m_axis_tdata[0]));
        if (m_axis_tdata[1] !== want[1])
          report_mismatch($sformatf("vertex_dropped expected %0b got %0b",
                                    want[1], m_axis_tdata[1]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Box mode: reset box, full range, inclusive bounds, inverted box, z widening
  task automatic test_box_bounds();
    send_item(make_item(OP_QUERY, 0, 0, 0, 7, 7, 7));
    send_item(make_item(OP_SET_BOX, COORD_BOT, COORD_BOT, COORD_BOT,
                        COORD_TOP, COORD_TOP, COORD_TOP));
    send_item(make_item(OP_QUERY, COORD_BOT, COORD_TOP, COORD_BOT, 0, 0, 0));
    send_item(make_item(OP_QUERY, COORD_TOP, COORD_BOT, COORD_TOP, -1, -1, -1));
    send_item(make_item(OP_SET_BOX, -10, -10, -10, 10, 10, 10));
    send_item(make_item(OP_QUERY, 10, -10, 10, 0, 0, 0));
    send_item(make_item(OP_QUERY, 11, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 11, 0, 0, 0));
    send_item(make_item(OP_SET_BOX, 5, -5, 0, -5, 5, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_SET_BOX, -10, -10, 0, 10, 10, 0));
    send_item(make_item(OP_WIDEN_Z, 1, 2, -100, 3, 4, 100));
    send_item(make_item(OP_QUERY, 0, 0, 50, 0, 0, 0));
  endtask

  // Degenerate rings, a triangle, and box mode keeping the vertices
  task automatic test_polygon_basics();
    send_item(make_item(OP_ADD_VERTEX, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ADD_VERTEX, 100, 100, 0, -1, -1, -1));
    send_item(make_item(OP_QUERY, 50, 50, 0, 0, 0, 0));
    send_item(make_item(OP_ADD_VERTEX, 100, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 60, 30, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 50, 50, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 100, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, -5, 5, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 60, 30, 500, 0, 0, 0));
    send_item(make_item(OP_SET_BOX, 0, 0, 0, 1, 1, 1));
    send_item(make_item(OP_QUERY, 60, 30, 0, 0, 0, 0));
    send_item(make_item(OP_ADD_VERTEX, 0, 100, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 1, 50, 0, 0, 0, 0));
  endtask

  // Grow the ring one vertex at a time with queries, boxes and z widening between
  task automatic test_polygon_growth();
    zone_item_t it;
    int r;
    while (n_vertices < MAX_VERTS - 4) begin
      if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        it = pick_vertex();
      end else if (r < 11) begin
        it = random_item(OP_WIDEN_Z);
        it.pz = near(0, 400);
        it.qz = near(0, 400);
      end else if (r < 13) begin
        it = random_item(OP_SET_BOX);
        it.px = near(-200, 200); it.py = near(-200, 200); it.pz = near(-50, 60);
        it.qx = near(200, 200); it.qy = near(200, 200); it.qz = near(50, 60);
      end else if (r < 15) begin
        it = random_item(op_t'($urandom_range(0, 3)));
      end else begin
        it = pick_query();
      end
      send_item(it);
    end
  endtask

  // Fill the store after a full drain, then add past the end
  task automatic test_store_full();
    drain_results();
    while (n_vertices < MAX_VERTS) begin
      send_item(pick_vertex());
      send_item(pick_query());
    end
    repeat (3) send_item(pick_vertex());
    repeat (3) send_item(pick_query());
  endtask

  // Longest ring: queries with refused vertices and z widening mixed in
  task automatic test_full_polygon_queries();
    zone_item_t it;
    int r;
    repeat (500) begin
      if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
      r = $urandom_range(0, 99);
      if (r < 85) begin
        it = pick_query();
      end else if (r < 92) begin
        it = random_item(OP_WIDEN_Z);
        it.pz = near(0, 2000);
        it.qz = near(0, 2000);
      end else if (r < 97) begin
        it = pick_vertex();
      end else begin
        it = random_item(op_t'($urandom_range(1, 3)));
      end
      send_item(it);
    end
  endtask

  // Random boxes, often inverted, with queries on and around the bounds
  task automatic test_random_boxes();
    zone_item_t it;
    int r;
    repeat (300) begin
      if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        it = random_item(OP_SET_BOX);
        if ($urandom_range(0, 1) == 0) begin
          it.qx = near(it.px, 1000); it.qy = near(it.py, 1000); it.qz = near(it.pz, 1000);
        end
      end else if (r < 22) begin
        it = random_item(OP_WIDEN_Z);
      end else if (r < 27) begin
        it = pick_vertex();
      end else if (r < 32) begin
        it = random_item(op_t'($urandom_range(0, 3)));
      end else begin
        it = random_item(OP_QUERY);
        it.px = box_axis(lo_c[0], hi_c[0]);
        it.py = box_axis(lo_c[1], hi_c[1]);
        it.pz = box_axis(lo_c[2], hi_c[2]);
      end
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_SET_BOX;
    no_gaps = 1'b0;
    error_count = 0;
    item_count = 0;
    query_count = 0;
    inside_count = 0;
    drop_count = 0;
    clear_zone();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_box_bounds();
    test_polygon_basics();
    test_polygon_growth();
    test_store_full();
    test_full_polygon_queries();
    test_random_boxes();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d queries, %0d inside, %0d refused vertices",
             item_count, query_count, inside_count, drop_count);
    $display("ring grown to %0d vertices, then random boxes and z ranges", n_vertices);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_flags_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
